[src/lphs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants of the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;
  localparam int MODE_W       = 2;
  localparam int KEY_W        = 16;
  localparam int CFG_W        = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } lphs_mode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic advance;
    logic store;
    logic clr_start;
    logic clr_step;
  } lphs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    lphs_mode_t mode;
    logic       div_last;
    logic       slot_empty;
    logic       key_match;
    logic       last_try;
    logic       clr_last;
  } lphs_sts_t;

endpackage

[src/lphs_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_req_if
// Request channel: operation code and key.
// ----------------------------------------------------------------------------
interface lphs_req_if;
  import lphs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

[src/lphs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_rsp_if
// Response channel: one success flag per request.
// ----------------------------------------------------------------------------
interface lphs_rsp_if;
  logic valid;
  logic ready;
  logic success;

  modport source (output valid, success, input ready);
  modport sink   (input valid, success, output ready);
endinterface

[src/linear_probe_hash_set_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Open-addressing hash set of integer keys with linear probing.
// ----------------------------------------------------------------------------
// One request at a time. An insert or lookup first forms the start slot (key
// mod table size, one quotient bit a cycle) and then reads and checks one slot
// per probe (single-port slot memory with registered read), at most table size
// probes. A clear sweeps the slot memory one slot a cycle. After reset the same
// sweep runs with ready low. The reply sits in an output register, so the next
// request is taken while a reply still waits. table_size is clamped to
// 1..CAPACITY and must be written only while the block is idle.
module linear_probe_hash_set_core #(
  parameter int CAPACITY = lphs_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lphs_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lphs_pkg::CFG_W-1:0] cfg_wdata,
  lphs_req_if.sink                   req,
  lphs_rsp_if.source                 rsp
);
  import lphs_pkg::*;

  lphs_cmd_t cmd;
  lphs_sts_t sts;

  lphs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .sts (sts),
    .cmd (cmd)
  );

  lphs_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mode      (req.mode),
    .key       (req.key),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[src/lphs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_datapath
// Table size register, bit-serial start index modulo, probe pointer and the
// slot memory holding {valid, key} per slot.
// ----------------------------------------------------------------------------
module lphs_datapath #(
  parameter int CAPACITY = lphs_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lphs_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [lphs_pkg::MODE_W-1:0] mode,
  input  logic [lphs_pkg::KEY_W-1:0]  key,
  input  lphs_pkg::lphs_cmd_t         cmd,
  output lphs_pkg::lphs_sts_t         sts
);
  import lphs_pkg::*;

  localparam int NW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(KEY_BITS);
  localparam int WW    = KEY_BITS + 1;

  logic [NW-1:0]       n;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] div_sh;
  logic [NW-1:0]       rem;
  logic [CNT_W-1:0]    cnt;
  lphs_mode_t          mode_q;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    tries;
  logic [IDX_W-1:0]    last_idx;
  logic [WW-1:0]       slot_mem [CAPACITY];
  logic [WW-1:0]       rd_word;

  logic [31:0]         key_wide;
  logic [KEY_BITS-1:0] key_in;
  logic [31:0]         cfg_wide;
  logic [NW-1:0]       n_next;
  logic [NW:0]         rem_sh;
  logic [NW-1:0]       rem_next;

  assign key_wide = 32'(key);
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign cfg_wide = 32'(cfg_wdata);
  assign last_idx = IDX_W'(n - NW'(1));

  // clamp the written size into 1..CAPACITY
  always_comb begin
    if (cfg_wide == 32'd0) begin
      n_next = NW'(1);
    end else if (cfg_wide > 32'(CAPACITY)) begin
      n_next = NW'(CAPACITY);
    end else begin
      n_next = NW'(cfg_wide);
    end
  end

  // one restoring step of key mod n
  always_comb begin
    rem_sh = {rem, div_sh[KEY_BITS-1]};
    if (rem_sh >= {1'b0, n}) begin
      rem_next = NW'(rem_sh - {1'b0, n});
    end else begin
      rem_next = NW'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= NW'(CAPACITY);
      idx   <= '0;
      tries <= '0;
    end else begin
      if (cfg_we) begin
        n <= n_next;
      end
      if (cmd.load) begin
        key_q  <= key_in;
        div_sh <= key_in;
        rem    <= '0;
        cnt    <= '0;
        mode_q <= lphs_mode_t'(mode);
      end
      if (cmd.div_step) begin
        rem    <= rem_next;
        div_sh <= {div_sh[KEY_BITS-2:0], 1'b0};
        cnt    <= cnt + CNT_W'(1);
        if (sts.div_last) begin
          idx   <= IDX_W'(rem_next);
          tries <= '0;
        end
      end
      if (cmd.advance) begin
        idx   <= (idx == last_idx) ? '0 : idx + IDX_W'(1);
        tries <= tries + IDX_W'(1);
      end
      if (cmd.clr_start) begin
        idx <= '0;
      end
      if (cmd.clr_step) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // single-port slot memory, registered read
  always_ff @(posedge clk) begin
    rd_word <= slot_mem[idx];
    if (cmd.store) begin
      slot_mem[idx] <= {1'b1, key_q};
    end else if (cmd.clr_step) begin
      slot_mem[idx] <= '0;
    end
  end

  assign sts.mode       = mode_q;
  assign sts.div_last   = (cnt == CNT_W'(KEY_BITS - 1));
  assign sts.slot_empty = ~rd_word[KEY_BITS];
  assign sts.key_match  = (rd_word[KEY_BITS-1:0] == key_q);
  assign sts.last_try   = (tries == last_idx);
  assign sts.clr_last   = (idx == IDX_W'(CAPACITY - 1));

endmodule

[src/lphs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_ctrl
// Sequencer for sweep, modulo, probe and reply, plus the response register.
// ----------------------------------------------------------------------------
module lphs_ctrl (
  input  logic                clk,
  input  logic                rst,
  lphs_req_if.sink            req,
  lphs_rsp_if.source          rsp,
  input  lphs_pkg::lphs_sts_t sts,
  output lphs_pkg::lphs_cmd_t cmd
);
  import lphs_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t state;
  logic   res;
  logic   op_pending;
  logic   out_valid;
  logic   out_success;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.success = out_success;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_SWEEP: cmd.clr_step = 1'b1;
      S_IDLE:  cmd.load = req.valid;
      S_DIV: begin
        unique case (sts.mode)
          MODE_CLEAR:               cmd.clr_start = 1'b1;
          MODE_INSERT, MODE_LOOKUP: cmd.div_step = 1'b1;
          default: ;
        endcase
      end
      S_CHK: begin
        if (sts.mode == MODE_INSERT) begin
          cmd.store   = sts.slot_empty;
          cmd.advance = ~sts.slot_empty & ~sts.last_try;
        end else begin
          cmd.advance = ~sts.slot_empty & ~sts.key_match & ~sts.last_try;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      op_pending <= 1'b0;
      out_valid  <= 1'b0;
      res        <= 1'b0;
    end else begin
      // drop the reply once the sink takes it
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          if (sts.clr_last) begin
            state <= op_pending ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          unique case (sts.mode)
            MODE_CLEAR: begin
              res        <= 1'b1;
              op_pending <= 1'b1;
              state      <= S_SWEEP;
            end
            MODE_INSERT, MODE_LOOKUP: begin
              if (sts.div_last) begin
                state <= S_RD;
              end
            end
            default: begin
              res   <= 1'b0;
              state <= S_FIN;
            end
          endcase
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          priority if (sts.mode == MODE_INSERT && sts.slot_empty) begin
            res   <= 1'b1;
            state <= S_FIN;
          end else if (sts.slot_empty) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else if (sts.mode == MODE_LOOKUP && sts.key_match) begin
            res   <= 1'b1;
            state <= S_FIN;
          end else if (sts.last_try) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_FIN: begin
          // hold until the reply register is free
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_success <= res;
            op_pending  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
